// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the colour-key centroid RTL.
// Each macro expects clk in the scope where it is used; CKC_ASSERT also expects an active-low rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define CKC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define CKC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/ckc_pkg.sv -----
// Package for the colour-key centroid block: default widths, register
// indexes, controller states and the controller-to-datapath command word.
// No dependencies.
`default_nettype none

package ckc_pkg;

  localparam int COORD_WIDTH_DEF = 10;
  localparam int COLOR_WIDTH_DEF = 16;

  // Configuration register indexes
  localparam int CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_KEY_COLOR    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW_X_MAX = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW_Y_MAX = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIVIDE,
    ST_EMIT
  } ckc_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic acc_en;    // a pixel word is accepted this cycle
    logic frame_end; // the accepted pixel closes the frame
    logic div_step;  // run one quotient bit of both divisions
    logic out_load;  // load the result register
  } ckc_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ckc_datapath.sv -----
// Datapath of the colour-key centroid block: configuration registers, match
// test, accumulators, two restoring dividers and the result register.
// Depends on ckc_pkg.
`default_nettype none

module ckc_datapath #(
  parameter int COORD_WIDTH = 10,
  parameter int COLOR_WIDTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire ckc_pkg::ckc_cmd_t            cmd,
  input  wire logic                         cfg_we,
  input  wire logic [ckc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [((COLOR_WIDTH > COORD_WIDTH) ? COLOR_WIDTH : COORD_WIDTH)-1:0] cfg_data,
  input  wire logic [COLOR_WIDTH-1:0]       pixel_color,
  input  wire logic [COORD_WIDTH-1:0]       pixel_x,
  input  wire logic [COORD_WIDTH-1:0]       pixel_y,
  output logic                              found,
  output logic [COORD_WIDTH-1:0]            centroid_x,
  output logic [COORD_WIDTH-1:0]            centroid_y
);
  import ckc_pkg::*;

  localparam int SUM_W = 3 * COORD_WIDTH;
  localparam int CNT_W = 2 * COORD_WIDTH + 1;

  logic [COLOR_WIDTH-1:0] key_color_r;
  logic [COORD_WIDTH-1:0] x_max_r;
  logic [COORD_WIDTH-1:0] y_max_r;

  logic [SUM_W-1:0] sum_x_r, sum_y_r;
  logic [CNT_W-1:0] count_r;
  logic [SUM_W-1:0] sum_x_nxt, sum_y_nxt;
  logic [CNT_W-1:0] count_nxt;
  logic             hit;

  logic [SUM_W-1:0]       rem_x_r, rem_y_r, dsh_r;
  logic [COORD_WIDTH-1:0] quo_x_r, quo_y_r;
  logic                   nonzero_r;
  logic                   x_ge, y_ge;

  logic                   found_r;
  logic [COORD_WIDTH-1:0] cen_x_r, cen_y_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_color_r <= '0;
      x_max_r     <= '1;
      y_max_r     <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_COLOR:    key_color_r <= cfg_data[COLOR_WIDTH-1:0];
        CFG_WINDOW_X_MAX: x_max_r     <= cfg_data[COORD_WIDTH-1:0];
        CFG_WINDOW_Y_MAX: y_max_r     <= cfg_data[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Match test; stop counting once 2^(2*COORD_WIDTH) pixels have matched
  assign hit = cmd.acc_en && (pixel_color == key_color_r) && (pixel_x <= x_max_r)
               && (pixel_y <= y_max_r) && !count_r[CNT_W-1];

  assign sum_x_nxt = hit ? sum_x_r + SUM_W'(pixel_x) : sum_x_r;
  assign sum_y_nxt = hit ? sum_y_r + SUM_W'(pixel_y) : sum_y_r;
  assign count_nxt = hit ? count_r + CNT_W'(1) : count_r;

  // Accumulate; clear at frame end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      count_r <= '0;
    end else if (cmd.frame_end) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      count_r <= '0;
    end else begin
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      count_r <= count_nxt;
    end
  end

  // Restoring division, one quotient bit per step, most significant first
  assign x_ge = rem_x_r >= dsh_r;
  assign y_ge = rem_y_r >= dsh_r;

  always_ff @(posedge clk) begin
    if (cmd.frame_end) begin
      rem_x_r   <= sum_x_nxt;
      rem_y_r   <= sum_y_nxt;
      dsh_r     <= SUM_W'(count_nxt) << (COORD_WIDTH - 1);
      quo_x_r   <= '0;
      quo_y_r   <= '0;
      nonzero_r <= count_nxt != '0;
    end else if (cmd.div_step) begin
      rem_x_r <= x_ge ? rem_x_r - dsh_r : rem_x_r;
      rem_y_r <= y_ge ? rem_y_r - dsh_r : rem_y_r;
      quo_x_r <= {quo_x_r[COORD_WIDTH-2:0], x_ge};
      quo_y_r <= {quo_y_r[COORD_WIDTH-2:0], y_ge};
      dsh_r   <= dsh_r >> 1;
    end
  end

  // Result register; force zeros when nothing matched
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found_r <= nonzero_r;
      cen_x_r <= nonzero_r ? quo_x_r : '0;
      cen_y_r <= nonzero_r ? quo_y_r : '0;
    end
  end

  assign found      = found_r;
  assign centroid_x = cen_x_r;
  assign centroid_y = cen_y_r;

endmodule

`default_nettype wire

// ----- hw/rtl/ckc_ctrl.sv -----
// Controller of the colour-key centroid block: frame state machine, division
// step counter and result-valid flag.
// Depends on ckc_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module ckc_ctrl #(
  parameter int COORD_WIDTH = 10
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  input  wire logic            in_tlast,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output ckc_pkg::ckc_cmd_t    cmd
);
  import ckc_pkg::*;

  localparam int STEP_W = $clog2(COORD_WIDTH);

  ckc_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  // State, counter and valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCUM;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_ACCUM: begin
        in_tready  = 1'b1;
        cmd.acc_en = in_tvalid;
        if (in_tvalid && in_tlast) begin
          cmd.frame_end = 1'b1;
          step_nxt      = STEP_W'(COORD_WIDTH - 1);
          state_nxt     = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_ACCUM;
        end
      end
      default: state_nxt = ST_ACCUM;
    endcase
  end

  // Hold the result word until it is taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

  `CKC_ASSERT(a_last_starts_divide, (in_tvalid && in_tready && in_tlast) |=> (state_r == ST_DIVIDE), "last pixel did not start division")
  `CKC_ASSERT(a_step_in_range, (state_r == ST_DIVIDE) |-> (step_r <= STEP_W'(COORD_WIDTH - 1)), "division step counter out of range")
  `CKC_ASSERT(a_load_when_free, cmd.out_load |-> (!out_valid_r || out_tready), "result overwritten before taken")
  `CKC_ASSERT(a_valid_after_emit, $rose(out_valid_r) |-> ($past(state_r) == ST_EMIT), "result valid without a finished division")

endmodule

`default_nettype wire

// ----- hw/rtl/color_key_centroid.sv -----
// Top level of the colour-key centroid block: port packing, controller and
// datapath. Depends on ckc_pkg, ckc_ctrl and ckc_datapath.
`default_nettype none

// Colour-key centroid. Pixels stream in one per cycle while in_tready is high;
// a pixel counts when its colour equals key_color and x <= window_x_max,
// y <= window_y_max. The word with tlast set closes the frame: after it
// in_tready stays low while a shared-step restoring divider produces one
// quotient bit per cycle for x and y in parallel, and while the previous
// result still waits on out_tready. One result word per frame leaves through
// an output register: tuser carries found, tdata the truncated mean x and y
// (zero when nothing matched). Counting stops at 2^(2*COORD_WIDTH) matches.
// Configuration writes are always accepted (cfg_ready is tied high); indexes
// beyond 2 are ignored.
module color_key_centroid #(
  parameter int COORD_WIDTH = ckc_pkg::COORD_WIDTH_DEF,
  parameter int COLOR_WIDTH = ckc_pkg::COLOR_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // tdata: pixel_color, pixel_x, pixel_y (lowest bits first), zero padded
  input  wire logic [((COLOR_WIDTH + 2 * COORD_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  input  wire logic in_tlast,  // last_pixel
  input  wire logic in_tvalid,
  output logic      in_tready,
  // tdata: centroid_x, centroid_y (lowest bits first), zero padded
  output logic [((2 * COORD_WIDTH + 7) / 8) * 8 - 1:0] out_tdata,
  output logic      out_tuser, // found
  output logic      out_tvalid,
  input  wire logic out_tready,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [ckc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [((COLOR_WIDTH > COORD_WIDTH) ? COLOR_WIDTH : COORD_WIDTH)-1:0] cfg_data
);
  import ckc_pkg::*;

  localparam int OUT_W = ((2 * COORD_WIDTH + 7) / 8) * 8;

  ckc_cmd_t               cmd;
  logic [COLOR_WIDTH-1:0] pixel_color;
  logic [COORD_WIDTH-1:0] pixel_x, pixel_y;
  logic [COORD_WIDTH-1:0] centroid_x, centroid_y;

  // Unpack the pixel word
  assign pixel_color = in_tdata[COLOR_WIDTH-1:0];
  assign pixel_x     = in_tdata[COLOR_WIDTH +: COORD_WIDTH];
  assign pixel_y     = in_tdata[COLOR_WIDTH + COORD_WIDTH +: COORD_WIDTH];

  assign cfg_ready = 1'b1;

  ckc_ctrl #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd)
  );

  ckc_datapath #(
    .COORD_WIDTH(COORD_WIDTH),
    .COLOR_WIDTH(COLOR_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel_color(pixel_color),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .found      (out_tuser),
    .centroid_x (centroid_x),
    .centroid_y (centroid_y)
  );

  // Pack the result word
  assign out_tdata = OUT_W'({centroid_y, centroid_x});

endmodule

`default_nettype wire
